// File: sv/rbpm_pkg.sv
`timescale 1ns / 1ps
// rbpm_pkg: shared constants, codes, types and helper functions of the
// refcounted buffer pool manager; no dependencies
package rbpm_pkg;

  localparam int PURE_DEPTH    = 32;
  localparam int COMMON_DEPTH  = 32;
  localparam int DYNAMIC_DEPTH = 32;

  localparam int NUM_POOLS     = 3;
  localparam int TOTAL_ENTRIES = PURE_DEPTH + COMMON_DEPTH + DYNAMIC_DEPTH;
  localparam int MAX_DEPTH     = (PURE_DEPTH > COMMON_DEPTH) ?
                                 ((PURE_DEPTH > DYNAMIC_DEPTH) ? PURE_DEPTH : DYNAMIC_DEPTH) :
                                 ((COMMON_DEPTH > DYNAMIC_DEPTH) ? COMMON_DEPTH : DYNAMIC_DEPTH);

  localparam int FUNC_W = 3;
  localparam int POOL_W = 2;
  localparam int IDX_W  = 8;
  localparam int STAT_W = 3;
  localparam int REF_W  = 6;
  localparam int CNT_W  = 9;
  localparam int NX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int SLOT_W = $clog2(TOTAL_ENTRIES);
  localparam int SUM_W  = 10;

  localparam logic [REF_W-1:0] REF_LIMIT_RST = 6'd7;

  localparam logic [FUNC_W-1:0] FN_ALLOC      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INC_REF    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FORCE_FREE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CHECK      = 3'd4;

  localparam logic [POOL_W-1:0] POOL_PURE    = 2'd0;
  localparam logic [POOL_W-1:0] POOL_COMMON  = 2'd1;
  localparam logic [POOL_W-1:0] POOL_DYNAMIC = 2'd2;
  localparam logic [POOL_W-1:0] POOL_INVALID = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd1;
  localparam logic [STAT_W-1:0] ST_LIMIT      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FREE       = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD        = 3'd4;
  localparam logic [STAT_W-1:0] ST_CHECK_FAIL = 3'd5;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [REF_W-1:0]  data;
  } ref_wr_t;

  function automatic logic [CNT_W-1:0] depth_of(input logic [POOL_W-1:0] p);
    case (p)
      POOL_PURE:   depth_of = CNT_W'(PURE_DEPTH);
      POOL_COMMON: depth_of = CNT_W'(COMMON_DEPTH);
      default:     depth_of = CNT_W'(DYNAMIC_DEPTH);
    endcase
  endfunction

  function automatic logic [SLOT_W-1:0] base_of(input logic [POOL_W-1:0] p);
    case (p)
      POOL_PURE:   base_of = '0;
      POOL_COMMON: base_of = SLOT_W'(PURE_DEPTH);
      default:     base_of = SLOT_W'(PURE_DEPTH + COMMON_DEPTH);
    endcase
  endfunction

  // flat slot of a handle; handles outside a pool map to slot zero
  function automatic logic [SLOT_W-1:0] slot_of(input logic [POOL_W-1:0] p,
                                                input logic [IDX_W-1:0]  idx);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base_of(p)) + SUM_W'(idx);
    if (p == POOL_INVALID || {1'b0, idx} >= depth_of(p)) begin
      slot_of = '0;
    end else begin
      slot_of = sum[SLOT_W-1:0];
    end
  endfunction

endpackage

// File: sv/rbpm_if.sv
`timescale 1ns / 1ps
// rbpm_in_if / rbpm_out_if: valid/ready channels of the buffer pool manager
// depends on rbpm_pkg for field widths
interface rbpm_in_if;
  logic                         valid;
  logic                         ready;
  logic [rbpm_pkg::FUNC_W-1:0]  func;
  logic [rbpm_pkg::POOL_W-1:0]  pool_id;
  logic [rbpm_pkg::IDX_W-1:0]   entry_index;

  modport source (output valid, func, pool_id, entry_index, input ready);
  modport sink   (input valid, func, pool_id, entry_index, output ready);
endinterface

interface rbpm_out_if;
  logic                         valid;
  logic                         ready;
  logic [rbpm_pkg::STAT_W-1:0]  status;
  logic [rbpm_pkg::POOL_W-1:0]  out_pool;
  logic [rbpm_pkg::IDX_W-1:0]   out_index;
  logic [rbpm_pkg::REF_W-1:0]   ref_now;
  logic                         was_freed;
  logic [rbpm_pkg::CNT_W-1:0]   pool_used;
  logic [rbpm_pkg::CNT_W-1:0]   pool_used_peak;

  modport source (output valid, status, out_pool, out_index, ref_now, was_freed,
                  pool_used, pool_used_peak, input ready);
  modport sink   (input valid, status, out_pool, out_index, ref_now, was_freed,
                  pool_used, pool_used_peak, output ready);
endinterface

// File: sv/refcounted_buffer_pool_manager_unit.sv
`timescale 1ns / 1ps
// refcounted_buffer_pool_manager_unit: top level, three LIFO buffer pools with
// reference counts; uses rbpm_pkg, rbpm_in_if, rbpm_out_if, rbpm_ref_store
//
//   port    dir  handshake    carries
//   in_ch   in   valid/ready  func, pool_id, entry_index
//   out_ch  out  valid/ready  status, out_pool, out_index, ref_now, was_freed,
//                             pool_used, pool_used_peak
//   cfg_*   in   cfg_we       ref_limit (6 bits)
//
// one item per cycle sustained while out_ch.ready is high; the transfer in loads stage one,
// and the result register is loaded from stage one when it is free
// the reference count memory is read with a registered read at the transfer in
// reset is synchronous and takes effect at once; no clearing pass
// out_ch.ready low holds the result register, then stage one, then in_ch.ready
module refcounted_buffer_pool_manager_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  rbpm_in_if.sink                     in_ch,
  rbpm_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [rbpm_pkg::REF_W-1:0]  cfg_data
);
  import rbpm_pkg::*;

  logic [REF_W-1:0]  limit_r;

  logic              s1_vld_r;
  logic [FUNC_W-1:0] s1_func_r;
  logic [POOL_W-1:0] s1_pool_r;
  logic [IDX_W-1:0]  s1_idx_r;

  logic              res_vld_r;
  logic [STAT_W-1:0] res_status_r;
  logic [POOL_W-1:0] res_pool_r;
  logic [IDX_W-1:0]  res_idx_r;
  logic [REF_W-1:0]  res_ref_r;
  logic              res_freed_r;
  logic [CNT_W-1:0]  res_used_r;
  logic [CNT_W-1:0]  res_peak_r;

  logic [IDX_W-1:0]  next_r  [NUM_POOLS][MAX_DEPTH];
  logic [NX_W-1:0]   head_r  [NUM_POOLS];
  logic              empty_r [NUM_POOLS];
  logic [CNT_W-1:0]  used_r  [NUM_POOLS];
  logic [CNT_W-1:0]  peak_r  [NUM_POOLS];

  logic              in_fire;
  logic              res_free;
  logic              s1_adv;

  logic [POOL_W-1:0] pi;
  logic              pool_bad;
  logic [CNT_W-1:0]  depth;
  logic [NX_W-1:0]   head;
  logic [IDX_W-1:0]  nxt_raw;
  logic [NX_W-1:0]   nhead;
  logic              in_range;
  logic [REF_W-1:0]  ref_rd;
  logic [CNT_W-1:0]  used_cur;
  logic [CNT_W-1:0]  used_inc;
  logic [SUM_W-1:0]  pop_sum;

  logic [STAT_W-1:0] st_o;
  logic [IDX_W-1:0]  idx_o;
  logic [REF_W-1:0]  ref_o;
  logic              freed_o;
  logic [CNT_W-1:0]  used_o;
  logic [CNT_W-1:0]  peak_o;
  logic              do_pop;
  logic              do_push;
  logic              wr_req;
  logic [SLOT_W-1:0] wr_slot;
  logic [REF_W-1:0]  wr_data;
  ref_wr_t           ref_wr;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign res_free    = !res_vld_r || out_ch.ready;
  assign s1_adv      = s1_vld_r && res_free;
  assign in_ch.ready = !s1_vld_r || res_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= REF_LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= in_ch.func;
      s1_pool_r <= in_ch.pool_id;
      s1_idx_r  <= in_ch.entry_index;
    end
  end

  rbpm_ref_store u_refs (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_slot (slot_of(in_ch.pool_id, in_ch.entry_index)),
    .wr      (ref_wr),
    .rd_data (ref_rd)
  );

  assign pool_bad = (s1_pool_r == POOL_INVALID);
  assign pi       = pool_bad ? POOL_PURE : s1_pool_r;
  assign depth    = depth_of(pi);
  assign head     = head_r[pi];
  assign nxt_raw  = next_r[pi][head];
  assign nhead    = ({1'b0, nxt_raw} >= depth) ? NX_W'({1'b0, nxt_raw} - depth)
                                               : NX_W'(nxt_raw);
  assign in_range = ({1'b0, s1_idx_r} < depth);
  assign used_cur = used_r[pi];
  assign used_inc = used_cur + CNT_W'(1);
  assign pop_sum  = SUM_W'(base_of(pi)) + SUM_W'(head);

  always_comb begin
    st_o    = ST_OK;
    idx_o   = s1_idx_r;
    ref_o   = '0;
    freed_o = 1'b0;
    used_o  = used_cur;
    peak_o  = peak_r[pi];
    do_pop  = 1'b0;
    do_push = 1'b0;
    wr_req  = 1'b0;
    wr_slot = slot_of(s1_pool_r, s1_idx_r);
    wr_data = '0;
    if (pool_bad) begin
      st_o   = (s1_func_r == FN_CHECK) ? ST_CHECK_FAIL : ST_BAD;
      used_o = '0;
      peak_o = '0;
    end else begin
      case (s1_func_r)
        FN_ALLOC: begin
          if (empty_r[pi]) begin
            st_o  = ST_EMPTY;
            idx_o = '0;
          end else begin
            idx_o   = IDX_W'(head);
            ref_o   = REF_W'(1);
            do_pop  = 1'b1;
            used_o  = used_inc;
            peak_o  = (used_inc > peak_r[pi]) ? used_inc : peak_r[pi];
            wr_req  = 1'b1;
            wr_slot = pop_sum[SLOT_W-1:0];
            wr_data = REF_W'(1);
          end
        end
        FN_INC_REF, FN_RELEASE, FN_FORCE_FREE, FN_CHECK: begin
          if (!in_range) begin
            st_o = (s1_func_r == FN_CHECK) ? ST_CHECK_FAIL : ST_BAD;
          end else if (s1_func_r == FN_CHECK) begin
            ref_o = ref_rd;
          end else if (ref_rd == '0) begin
            st_o = ST_FREE;
          end else if (s1_func_r == FN_INC_REF) begin
            if (ref_rd >= limit_r) begin
              st_o  = ST_LIMIT;
              ref_o = ref_rd;
            end else begin
              ref_o   = ref_rd + REF_W'(1);
              wr_req  = 1'b1;
              wr_data = ref_rd + REF_W'(1);
            end
          end else begin
            // release drops one reference, force free drops them all
            ref_o   = (s1_func_r == FN_RELEASE) ? ref_rd - REF_W'(1) : '0;
            wr_req  = 1'b1;
            wr_data = ref_o;
            if (ref_o == '0) begin
              do_push = 1'b1;
              freed_o = 1'b1;
              used_o  = (used_cur != '0) ? used_cur - CNT_W'(1) : used_cur;
            end
          end
        end
        default: begin
          st_o = ST_BAD;
        end
      endcase
    end
  end

  always_comb begin
    ref_wr.en   = wr_req && s1_adv;
    ref_wr.slot = wr_slot;
    ref_wr.data = wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        for (int i = 0; i < MAX_DEPTH; i++) begin
          next_r[p][i] <= IDX_W'(i + 1);
        end
        head_r[p]  <= '0;
        empty_r[p] <= 1'b0;
        used_r[p]  <= '0;
        peak_r[p]  <= '0;
      end
    end else if (s1_adv) begin
      if (do_pop) begin
        head_r[pi]  <= nhead;
        used_r[pi]  <= used_o;
        peak_r[pi]  <= peak_o;
        empty_r[pi] <= (used_o >= depth);
      end
      if (do_push) begin
        next_r[pi][s1_idx_r[NX_W-1:0]] <= IDX_W'(head);
        head_r[pi]  <= s1_idx_r[NX_W-1:0];
        empty_r[pi] <= 1'b0;
        used_r[pi]  <= used_o;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (res_free) begin
      res_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_status_r <= st_o;
      res_pool_r   <= s1_pool_r;
      res_idx_r    <= idx_o;
      res_ref_r    <= ref_o;
      res_freed_r  <= freed_o;
      res_used_r   <= used_o;
      res_peak_r   <= peak_o;
    end
  end

  assign out_ch.valid          = res_vld_r;
  assign out_ch.status         = res_status_r;
  assign out_ch.out_pool       = res_pool_r;
  assign out_ch.out_index      = res_idx_r;
  assign out_ch.ref_now        = res_ref_r;
  assign out_ch.was_freed      = res_freed_r;
  assign out_ch.pool_used      = res_used_r;
  assign out_ch.pool_used_peak = res_peak_r;

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && res_vld_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while both stages are stalled");

  a_used_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> (used_r[pi] <= depth))
    else $error("in-use count beyond pool depth");

  a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> (empty_r[pi] == (used_r[pi] == depth)))
    else $error("empty flag disagrees with in-use count");

  a_peak_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> (peak_r[pi] >= used_r[pi]))
    else $error("peak count below in-use count");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> res_vld_r)
    else $error("advanced item produced no result");

endmodule

// File: sv/rbpm_ref_store.sv
`timescale 1ns / 1ps
// rbpm_ref_store: reference count memory with registered read, per-entry
// valid bits (invalid reads as zero) and forwarding of the last write; uses rbpm_pkg
module rbpm_ref_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [rbpm_pkg::SLOT_W-1:0]  rd_slot,
  input  rbpm_pkg::ref_wr_t            wr,
  output logic [rbpm_pkg::REF_W-1:0]   rd_data
);
  import rbpm_pkg::*;

  logic [REF_W-1:0]         ref_mem_r [TOTAL_ENTRIES];
  logic [TOTAL_ENTRIES-1:0] valid_r;
  logic [REF_W-1:0]         mem_q_r;
  logic                     val_q_r;
  logic [SLOT_W-1:0]        slot_r;
  ref_wr_t                  last_r;
  logic                     hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ref_mem_r[wr.slot] <= wr.data;
    end
    if (rd_en) begin
      mem_q_r <= ref_mem_r[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      last_r  <= '0;
      val_q_r <= 1'b0;
      slot_r  <= '0;
    end else begin
      if (wr.en) begin
        valid_r[wr.slot] <= 1'b1;
        last_r           <= wr;
      end
      if (rd_en) begin
        val_q_r <= valid_r[rd_slot];
        slot_r  <= rd_slot;
      end
    end
  end

  // a write at the read edge is not seen by the registered read
  assign hit     = last_r.en && (last_r.slot == slot_r);
  assign rd_data = hit ? last_r.data : (val_q_r ? mem_q_r : '0);

endmodule

// File: dv/rbpm_pool_checker.sv
`timescale 1ns / 1ps
// rbpm_pool_checker: watches the request, result and ref_limit ports of the pool manager,
// predicts each result from its own copy of the pool state and compares field by field
// depends on rbpm_pkg and the rbpm_in_if / rbpm_out_if interfaces
module rbpm_pool_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  rbpm_in_if                          in_ch,
  rbpm_out_if                         out_ch,
  input  logic                        cfg_we,
  input  logic [rbpm_pkg::REF_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          outstanding
);
  import rbpm_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POOL_W-1:0] pool;
    logic [IDX_W-1:0]  index;
    logic [REF_W-1:0]  refs;
    logic              freed;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  peak;
  } pool_result_t;

  logic [IDX_W-1:0] link_tbl    [0:NUM_POOLS-1][0:MAX_DEPTH-1];
  logic [REF_W-1:0] ref_cnt     [0:NUM_POOLS-1][0:MAX_DEPTH-1];
  logic [CNT_W-1:0] head        [0:NUM_POOLS-1];
  logic             full_flag   [0:NUM_POOLS-1];
  logic [CNT_W-1:0] in_use      [0:NUM_POOLS-1];
  logic [CNT_W-1:0] in_use_peak [0:NUM_POOLS-1];
  logic [REF_W-1:0] limit;

  pool_result_t due_results[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic int pool_depth(input logic [POOL_W-1:0] p);
    case (p)
      POOL_PURE:   return PURE_DEPTH;
      POOL_COMMON: return COMMON_DEPTH;
      default:     return DYNAMIC_DEPTH;
    endcase
  endfunction

  function automatic void reset_pools();
    for (int p = 0; p < NUM_POOLS; p++) begin
      for (int i = 0; i < MAX_DEPTH; i++) begin
        link_tbl[p][i] = IDX_W'(i + 1);
        ref_cnt[p][i]  = '0;
      end
      head[p]        = '0;
      full_flag[p]   = 1'b0;
      in_use[p]      = '0;
      in_use_peak[p] = '0;
    end
    limit = REF_LIMIT_RST;
  endfunction

  function automatic void push_free(input logic [POOL_W-1:0] p, input logic [IDX_W-1:0] e);
    link_tbl[p][e] = head[p][IDX_W-1:0];
    head[p]        = CNT_W'(e);
    full_flag[p]   = 1'b0;
    if (in_use[p] != 0) in_use[p] = in_use[p] - CNT_W'(1);
  endfunction

  function automatic pool_result_t apply_pool_op(input logic [FUNC_W-1:0] op,
                                                 input logic [POOL_W-1:0] p,
                                                 input logic [IDX_W-1:0]  e);
    pool_result_t r;
    int d;
    int h;
    r       = '0;
    r.pool  = p;
    r.index = e;
    if (p == POOL_INVALID) begin
      r.status = (op == FN_CHECK) ? ST_CHECK_FAIL : ST_BAD;
      return r;
    end
    d = pool_depth(p);
    if (op == FN_ALLOC) begin
      if (full_flag[p]) begin
        r.status = ST_EMPTY;
        r.index  = '0;
      end else begin
        h              = int'(head[p]) % d;
        r.index        = IDX_W'(h);
        head[p]        = CNT_W'(int'(link_tbl[p][h]) % d);
        in_use[p]      = in_use[p] + CNT_W'(1);
        if (in_use[p] > in_use_peak[p]) in_use_peak[p] = in_use[p];
        full_flag[p]   = (int'(in_use[p]) >= d);
        ref_cnt[p][h]  = REF_W'(1);
        r.refs         = REF_W'(1);
      end
    end else if (op > FN_CHECK) begin
      r.status = ST_BAD;
    end else if (int'(e) >= d) begin
      r.status = (op == FN_CHECK) ? ST_CHECK_FAIL : ST_BAD;
    end else begin
      r.refs = ref_cnt[p][e];
      if (op == FN_CHECK) begin
        r.status = ST_OK;
      end else if (r.refs == 0) begin
        r.status = ST_FREE;
      end else if (op == FN_INC_REF) begin
        if (r.refs >= limit) begin
          r.status = ST_LIMIT;
        end else begin
          r.refs         = r.refs + REF_W'(1);
          ref_cnt[p][e]  = r.refs;
        end
      end else if (op == FN_RELEASE) begin
        r.refs        = r.refs - REF_W'(1);
        ref_cnt[p][e] = r.refs;
        if (r.refs == 0) begin
          push_free(p, e);
          r.freed = 1'b1;
        end
      end else begin
        r.refs        = '0;
        ref_cnt[p][e] = '0;
        push_free(p, e);
        r.freed = 1'b1;
      end
    end
    r.used = in_use[p];
    r.peak = in_use_peak[p];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pool_result_t want;
    if (!rst_n) begin
      reset_pools();
      due_results.delete();
    end else begin
      if (cfg_we) limit = cfg_data;
      if (in_ch.valid && in_ch.ready) begin
        due_results.push_back(apply_pool_op(in_ch.func, in_ch.pool_id, in_ch.entry_index));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d index %0d",
                   $time, out_ch.status, out_ch.out_index);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("status", CNT_W'(want.status), CNT_W'(out_ch.status));
          check_field("out_pool", CNT_W'(want.pool), CNT_W'(out_ch.out_pool));
          check_field("out_index", CNT_W'(want.index), CNT_W'(out_ch.out_index));
          check_field("ref_now", CNT_W'(want.refs), CNT_W'(out_ch.ref_now));
          check_field("was_freed", CNT_W'(want.freed), CNT_W'(out_ch.was_freed));
          check_field("pool_used", want.used, out_ch.pool_used);
          check_field("pool_used_peak", want.peak, out_ch.pool_used_peak);
        end
      end
    end
    outstanding <= due_results.size();
  end

endmodule

// File: dv/refcounted_buffer_pool_manager_unit_tb.sv
`timescale 1ns / 1ps
// refcounted_buffer_pool_manager_unit_tb: drives directed and random pool requests
// with ref_limit changes between phases and gives the verdict
// depends on rbpm_pkg, rbpm_if.sv, the pool manager rtl and rbpm_pool_checker
module refcounted_buffer_pool_manager_unit_tb;
  import rbpm_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 205;

  localparam logic [FUNC_W-1:0] FN_BAD_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_BAD_MID = 3'd6;
  localparam logic [FUNC_W-1:0] FN_BAD_HI = 3'd7;

  // limit 0 here means a random limit
  int phase_limit [PHASES] = '{1, 63, 0, 3, 63, 0, 1, 0, 7};
  bit phase_fill  [PHASES] = '{1, 1, 0, 1, 0, 1, 0, 1, 0};
  bit phase_idle  [PHASES] = '{1, 1, 1, 0, 1, 1, 1, 1, 0};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [REF_W-1:0] cfg_data;
  bit idle_on = 1'b1;
  int fail_count;
  int outstanding;

  rbpm_in_if  in_ch ();
  rbpm_out_if out_ch ();

  refcounted_buffer_pool_manager_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  rbpm_pool_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_op(input logic [FUNC_W-1:0] op, input logic [POOL_W-1:0] p,
                         input logic [IDX_W-1:0] e);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= op;
    in_ch.pool_id     <= p;
    in_ch.entry_index <= e;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_limit(input logic [REF_W-1:0] v);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_ops(input int count, input bit filling);
    int w;
    logic [FUNC_W-1:0] op;
    logic [POOL_W-1:0] p;
    logic [IDX_W-1:0]  e;
    repeat (count) begin
      p = POOL_W'($urandom_range(0, 2));
      case (p)
        POOL_PURE:   e = IDX_W'($urandom_range(0, PURE_DEPTH - 1));
        POOL_COMMON: e = IDX_W'($urandom_range(0, COMMON_DEPTH - 1));
        default:     e = IDX_W'($urandom_range(0, DYNAMIC_DEPTH - 1));
      endcase
      w = $urandom_range(0, 99);
      if (filling) begin
        op = (w < 50) ? FN_ALLOC : (w < 70) ? FN_INC_REF : (w < 78) ? FN_RELEASE :
             (w < 82) ? FN_FORCE_FREE : FN_CHECK;
      end else begin
        op = (w < 15) ? FN_ALLOC : (w < 30) ? FN_INC_REF : (w < 70) ? FN_RELEASE :
             (w < 85) ? FN_FORCE_FREE : FN_CHECK;
      end
      // noise: any code, any pool, full index range
      if ($urandom_range(0, 99) < 6) begin
        op = FUNC_W'($urandom_range(0, 7));
        p  = POOL_W'($urandom_range(0, 3));
        e  = IDX_W'($urandom_range(0, 255));
      end
      send_op(op, p, e);
    end
  endtask

  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        hold = $urandom_range(1, 13) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("refcounted_buffer_pool_manager_unit regression: fail");
    $finish;
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_data          <= REF_LIMIT_RST;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= FN_CHECK;
    in_ch.pool_id     <= POOL_PURE;
    in_ch.entry_index <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // invalid pool and unknown codes
    send_op(FN_CHECK, POOL_INVALID, 8'd0);
    send_op(FN_ALLOC, POOL_INVALID, 8'd255);
    send_op(FN_BAD_HI, POOL_INVALID, 8'd255);
    // one entry through its whole life, then misuse of the freed entry
    send_op(FN_ALLOC, POOL_PURE, 8'd0);
    send_op(FN_INC_REF, POOL_PURE, 8'd0);
    send_op(FN_CHECK, POOL_PURE, 8'd0);
    send_op(FN_RELEASE, POOL_PURE, 8'd0);
    send_op(FN_RELEASE, POOL_PURE, 8'd0);
    send_op(FN_RELEASE, POOL_PURE, 8'd0);
    send_op(FN_FORCE_FREE, POOL_PURE, 8'd0);
    send_op(FN_INC_REF, POOL_PURE, 8'd0);
    send_op(FN_ALLOC, POOL_COMMON, 8'd0);
    send_op(FN_FORCE_FREE, POOL_COMMON, 8'd0);
    // handle range edges
    send_op(FN_CHECK, POOL_DYNAMIC, 8'd31);
    send_op(FN_CHECK, POOL_COMMON, 8'd32);
    send_op(FN_RELEASE, POOL_DYNAMIC, 8'd255);
    send_op(FN_BAD_LO, POOL_PURE, 8'd3);
    send_op(FN_BAD_MID, POOL_COMMON, 8'd40);
    send_op(FN_ALLOC, POOL_DYNAMIC, 8'd0);
    // count at the limit
    write_limit(REF_W'(1));
    send_op(FN_INC_REF, POOL_DYNAMIC, 8'd0);
    send_op(FN_RELEASE, POOL_DYNAMIC, 8'd0);

    for (int i = 0; i < PHASES; i++) begin
      if (phase_limit[i] == 0) write_limit(REF_W'($urandom_range(1, 63)));
      else write_limit(REF_W'(phase_limit[i]));
      idle_on = phase_idle[i];
      random_ops(PHASE_ITEMS, phase_fill[i]);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("refcounted_buffer_pool_manager_unit regression: pass");
    end else begin
      $display("refcounted_buffer_pool_manager_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: refcounted_buffer_pool_manager_unit.f
sv/rbpm_pkg.sv
sv/rbpm_if.sv
sv/rbpm_ref_store.sv
sv/refcounted_buffer_pool_manager_unit.sv
dv/rbpm_pool_checker.sv
dv/refcounted_buffer_pool_manager_unit_tb.sv
